[hdl/gfcb_pkg.sv]
// Shared types, codes and the divisor table for the gated frequency counter.
package gfcb_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_EVENT  = 2'd1,
    FUNC_TOGGLE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    CFG_GATE_TICKS     = 2'd0,
    CFG_BLINK_PERIOD   = 2'd1,
    CFG_BLINK_ON_TICKS = 2'd2
  } cfg_index_e;

  localparam int unsigned PhaseW = 14;
  localparam int unsigned WrapW  = 16;
  localparam int unsigned FreqW  = 32;
  localparam int unsigned ProdW  = PhaseW + WrapW;

  localparam logic [1:0]        SelReset = 2'd1;
  localparam logic [7:0]        GateTicksReset = 8'd100;
  localparam logic [3:0]        BlinkPeriodReset = 4'd12;
  localparam logic [3:0]        BlinkOnReset = 4'd2;
  localparam logic [WrapW-1:0]  WrapMax = {WrapW{1'b1}};

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] count_select;
  } req_t;

  typedef struct packed {
    logic             led;
    logic             divided_out;
    logic [FreqW-1:0] frequency;
    logic             measure_done;
  } res_t;

  function automatic logic [PhaseW-1:0] divisor(input logic [1:0] sel);
    logic [PhaseW-1:0] d;
    case (sel)
      2'd0:    d = 14'd10;
      2'd1:    d = 14'd100;
      2'd2:    d = 14'd1000;
      default: d = 14'd10000;
    endcase
    return d;
  endfunction

endpackage

[hdl/gfcb_outbuf.sv]
// Two-entry result buffer: an output register with a skid register behind it.
module gfcb_outbuf
  import gfcb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic ready_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_data_q, skid_data_q;
  logic pop;

  assign pop     = out_valid_q && ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (pop) begin
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_d = push_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (!out_valid_q || pop) begin
      if (push_i) begin
        out_data_q <= data_i;
      end
    end else if (push_i) begin
      skid_data_q <= data_i;
    end
  end

endmodule

[hdl/gated_frequency_counter_with_blink_core.sv]
// Top level of the gated frequency counter with divided output and blinking LED.
// Latency: a request's result is valid in the cycle after it is accepted, unless it waits in the skid register.
// Throughput: one request per cycle while the skid register is empty; each request updates the state in a single pass.
// A two-entry result buffer keeps the input ready while one result waits.
// Reset is asynchronous and active low; it restores all core registers to their defaults
// and leaves the result buffer empty; the buffer's data registers are not reset.
module gated_frequency_counter_with_blink_core
  import gfcb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic [7:0]        gate_ticks_q;
  logic [3:0]        blink_period_q, blink_on_q;

  logic [1:0]        div_sel_q, div_sel_d;
  logic [1:0]        act_sel_q, act_sel_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [PhaseW-1:0] old_phase_q, old_phase_d;
  logic [WrapW-1:0]  wrap_cnt_q, wrap_cnt_d;
  logic [7:0]        gate_cnt_q, gate_cnt_d;
  logic [3:0]        blink_cnt_q, blink_cnt_d;
  logic              mode_off_q, mode_off_d;
  logic              toggle_q, toggle_d;
  logic              div_lvl_q, div_lvl_d;
  logic              led_q, led_d;
  logic [FreqW-1:0]  freq_q, freq_d;

  logic              accept;
  logic              done;
  logic [7:0]        gate_inc;
  logic [4:0]        blink_inc;
  logic [PhaseW-1:0] phase_inc;
  logic [ProdW-1:0]  prod;
  logic [PhaseW:0]   diff;
  logic [FreqW:0]    sum;
  res_t              res;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_ticks_q   <= GateTicksReset;
      blink_period_q <= BlinkPeriodReset;
      blink_on_q     <= BlinkOnReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GATE_TICKS:     gate_ticks_q   <= cfg_data_i;
        CFG_BLINK_PERIOD:   blink_period_q <= cfg_data_i[3:0];
        CFG_BLINK_ON_TICKS: blink_on_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Gate measurement: wraps times divisor plus the signed phase change.
  assign prod = {{(ProdW - WrapW){1'b0}}, wrap_cnt_q}
              * {{(ProdW - PhaseW){1'b0}}, divisor(div_sel_q)};
  assign diff = {1'b0, phase_q} - {1'b0, old_phase_q};
  assign sum  = {{(FreqW + 1 - ProdW){1'b0}}, prod}
              + {{(FreqW - PhaseW){diff[PhaseW]}}, diff};

  assign gate_inc  = gate_cnt_q + 8'd1;
  assign blink_inc = {1'b0, blink_cnt_q} + 5'd1;
  assign phase_inc = phase_q + 14'd1;

  always_comb begin
    div_sel_d   = div_sel_q;
    act_sel_d   = act_sel_q;
    phase_d     = phase_q;
    old_phase_d = old_phase_q;
    wrap_cnt_d  = wrap_cnt_q;
    gate_cnt_d  = gate_cnt_q;
    blink_cnt_d = blink_cnt_q;
    mode_off_d  = mode_off_q;
    toggle_d    = toggle_q;
    div_lvl_d   = div_lvl_q;
    led_d       = led_q;
    freq_d      = freq_q;
    done        = 1'b0;
    case (in_req_i.func)
      FUNC_TICK: begin
        gate_cnt_d = gate_inc;
        if (gate_inc >= gate_ticks_q) begin
          gate_cnt_d  = '0;
          freq_d      = sum[FreqW] ? '0 : sum[FreqW-1:0];
          old_phase_d = phase_q;
          wrap_cnt_d  = '0;
          done        = 1'b1;
        end
        if (toggle_q) begin
          toggle_d   = 1'b0;
          mode_off_d = !mode_off_q;
        end
        blink_cnt_d = (blink_inc >= {1'b0, blink_period_q}) ? 4'd0 : blink_inc[3:0];
        led_d       = !mode_off_d && (blink_cnt_d < blink_on_q);
        div_sel_d   = in_req_i.count_select;
      end
      FUNC_EVENT: begin
        phase_d = phase_inc;
        if (phase_inc >= divisor(act_sel_q)) begin
          phase_d   = '0;
          div_lvl_d = !div_lvl_q;
          if (wrap_cnt_q != WrapMax) begin
            wrap_cnt_d = wrap_cnt_q + 16'd1;
          end
          act_sel_d = div_sel_q;
        end
      end
      FUNC_TOGGLE: begin
        toggle_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_sel_q   <= SelReset;
      act_sel_q   <= SelReset;
      phase_q     <= '0;
      old_phase_q <= '0;
      wrap_cnt_q  <= '0;
      gate_cnt_q  <= '0;
      blink_cnt_q <= '0;
      mode_off_q  <= 1'b0;
      toggle_q    <= 1'b0;
      div_lvl_q   <= 1'b0;
      led_q       <= 1'b0;
      freq_q      <= '0;
    end else if (accept) begin
      div_sel_q   <= div_sel_d;
      act_sel_q   <= act_sel_d;
      phase_q     <= phase_d;
      old_phase_q <= old_phase_d;
      wrap_cnt_q  <= wrap_cnt_d;
      gate_cnt_q  <= gate_cnt_d;
      blink_cnt_q <= blink_cnt_d;
      mode_off_q  <= mode_off_d;
      toggle_q    <= toggle_d;
      div_lvl_q   <= div_lvl_d;
      led_q       <= led_d;
      freq_q      <= freq_d;
    end
  end

  assign res.led          = led_d;
  assign res.divided_out  = div_lvl_d;
  assign res.frequency    = freq_d;
  assign res.measure_done = done;

  gfcb_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res_o)
  );

endmodule

[hdl/gfcb_checker.sv]
// Port-level checker for the gated frequency counter, bound to the top level.
module gfcb_checker
  import gfcb_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input res_t       out_res_o
);

  // An empty result buffer never stalls the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result buffer");

  // Every accepted request shows a result in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("accepted request produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_res_o))
    else $error("result changed while stalled");

endmodule

bind gated_frequency_counter_with_blink_core gfcb_checker u_gfcb_checker (.*);
